// ===== hw/rtl/isort_pkg.sv =====
// Shared types and constants for the insertion sorter.
// Used by isort_cell and insertion_sorter; no dependencies.
package isort_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic insert;  // place a new element, shifting larger entries up
    logic shift;   // move every entry down one place toward the output
  } cell_ctl_t;

endpackage

// ===== hw/rtl/insertion_sorter.sv =====
// Top level of the insertion sorter: a chain of isort_cell instances
// plus the collect/drain controller. Depends on isort_pkg and isort_cell.
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+--------------------------
//  input   | element, final_element                     | start && !busy
//  result  | sorted_value, final_result, overflowed     | strobe, no stall
//
// Flow: a non-final element is taken whenever busy is low, back to back;
// every cell compares against it in parallel and larger entries move up one
// place. A final element is inserted the same way, then the chain shifts
// toward cell 0 once per cycle, giving one result beat per stored entry
// (1 to DEPTH beats). busy is high for exactly those drain cycles.
// Reset clears the cell valid bits, the overflow flag and the controller;
// stored values are not reset. Results cannot be stalled by the receiver.
module insertion_sorter #(
  parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [isort_pkg::DATA_W-1:0] element,
  input  logic                                final_element,
  output logic                                strobe,
  output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
  output logic                                final_result,
  output logic                                overflowed
);

  isort_pkg::state_t    state, state_next;
  isort_pkg::cell_ctl_t ctl;
  logic                 overflow_seen;
  logic                 accept;
  logic                 full;
  logic                 last_beat;

  logic signed [isort_pkg::DATA_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]                    cell_valid;
  logic [DEPTH-1:0]                    cell_gt;
  logic [DEPTH-1:0]                    valid_inc;

  assign busy      = (state == isort_pkg::ST_DRAIN);
  assign accept    = start && !busy;
  // Store is full once the top cell holds an entry; further beats drop.
  assign full      = cell_valid[DEPTH-1];
  // Last result: nothing stored above cell 0.
  assign last_beat = busy && !cell_valid[1];

  assign ctl.insert = accept && !full;
  assign ctl.shift  = busy;

  // ---- cell chain ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [isort_pkg::DATA_W-1:0] lv, rv;
    logic                                lval, lgt, rval;
    if (i == 0) begin : g_first
      assign lv   = element;
      assign lval = 1'b1;
      assign lgt  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lval = cell_valid[i-1];
      assign lgt  = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_inner
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end
    isort_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .elem        (element),
      .left_value  (lv),
      .left_valid  (lval),
      .left_gt     (lgt),
      .right_value (rv),
      .right_valid (rval),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // ---- controller ----
  always_comb begin
    state_next = state;
    unique case (state)
      isort_pkg::ST_COLLECT: begin
        if (accept && final_element) state_next = isort_pkg::ST_DRAIN;
      end
      isort_pkg::ST_DRAIN: begin
        if (last_beat) state_next = isort_pkg::ST_COLLECT;
      end
      default: state_next = isort_pkg::ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isort_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Set on a dropped element (final one included), cleared after the list drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (last_beat) begin
      overflow_seen <= 1'b0;
    end else if (accept && full) begin
      overflow_seen <= 1'b1;
    end
  end

  // ---- result beat: always taken from cell 0 ----
  assign strobe       = busy;
  assign sorted_value = cell_value[0];
  assign final_result = last_beat;
  assign overflowed   = overflow_seen;

  // ---- checks ----
  assign valid_inc = cell_valid + DEPTH'(1);

  // Occupied cells always form a contiguous run from cell 0.
  a_thermo: assert property (@(posedge clk) disable iff (rst)
    (valid_inc & cell_valid) == '0)
    else $error("cell valid bits not contiguous");

  // Every result beat carries a stored entry.
  a_beat_valid: assert property (@(posedge clk) disable iff (rst)
    strobe |-> cell_valid[0])
    else $error("result beat from empty cell");

  // Draining starts only after a final element was taken.
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && final_element))
    else $error("drain without final element");

  // After the final beat the store is empty and the block is free.
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    final_result |=> (!busy && !cell_valid[0] && !overflowed))
    else $error("store not cleared after final beat");

endmodule

// ===== hw/rtl/isort_cell.sv =====
// One compare-and-hold cell of the sorting chain.
// Depends on isort_pkg (cell_ctl_t, DATA_W).
module isort_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  isort_pkg::cell_ctl_t                ctl,
  input  logic signed [isort_pkg::DATA_W-1:0] elem,
  input  logic signed [isort_pkg::DATA_W-1:0] left_value,
  input  logic                                left_valid,
  input  logic                                left_gt,
  input  logic signed [isort_pkg::DATA_W-1:0] right_value,
  input  logic                                right_valid,
  output logic signed [isort_pkg::DATA_W-1:0] value,
  output logic                                valid,
  output logic                                gt
);

  // An empty cell counts as greater than anything, so the first free
  // cell picks up the element or the entry that moves up into it.
  assign gt = !valid || (value > elem);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= right_value;
    end else if (ctl.insert && gt) begin
      value <= left_gt ? left_value : elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.insert) begin
      valid <= valid | left_valid;
    end
  end

endmodule
